// File: src/scaled_rect_blit_addr_gen_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaled rectangle blit address generator
// Shared helpers that keep the concurrent checks in the RTL short and uniform.
// ----------------------------------------------------------------------------
`ifndef SCALED_RECT_BLIT_ADDR_GEN_UNIT_DEFINES_SVH
`define SCALED_RECT_BLIT_ADDR_GEN_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRBAG_ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("srbag assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SRBAG_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("srbag assertion failed");

`endif

// File: src/srbag_pkg.sv
// ----------------------------------------------------------------------------
// Scaled rectangle blit address generator package
// Widths, codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package srbag_pkg;

   localparam int COORD_BITS     = 10;
   localparam int ADDR_BITS      = 20;
   localparam int SIZE_BITS      = COORD_BITS + 1;
   localparam int PROD_BITS      = 2 * COORD_BITS;
   localparam int SUM_BITS       = ((ADDR_BITS > PROD_BITS) ? ADDR_BITS : PROD_BITS) + 1;
   localparam int REQ_DATA_BITS  = ((8 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS  = ((2 * ADDR_BITS + 7) / 8) * 8;
   localparam int STATUS_BITS    = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = ADDR_BITS;
   localparam int DIV_CNT_BITS   = $clog2(COORD_BITS);
   localparam int NUM_LANES      = 2;

   localparam logic [COORD_BITS-1:0] DST_WIDTH_RESET  = COORD_BITS'(240);
   localparam logic [COORD_BITS-1:0] DST_HEIGHT_RESET = COORD_BITS'(320);
   localparam logic [COORD_BITS-1:0] DST_STRIDE_RESET = COORD_BITS'(240);
   localparam logic [COORD_BITS-1:0] SRC_WIDTH_RESET  = COORD_BITS'(1);
   localparam logic [COORD_BITS-1:0] SRC_HEIGHT_RESET = COORD_BITS'(1);

   typedef enum logic [0:0] {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } command_type;

   typedef enum logic [STATUS_BITS-1:0] {
      RSP_PAIR     = 3'd0,
      RSP_LAST     = 3'd1,
      RSP_ACCEPTED = 3'd2,
      RSP_REJECTED = 3'd3,
      RSP_IDLE     = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DST_BASE   = 3'd0,
      CSR_DST_WIDTH  = 3'd1,
      CSR_DST_HEIGHT = 3'd2,
      CSR_DST_STRIDE = 3'd3,
      CSR_SRC_BASE   = 3'd4,
      CSR_SRC_WIDTH  = 3'd5,
      CSR_SRC_HEIGHT = 3'd6
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_COMMIT,
      S_ACCEPT,
      S_REJECT,
      S_IDLE_REPLY,
      S_MUL,
      S_DIV_INIT,
      S_DIV,
      S_MUL2,
      S_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic       capture;
      logic       check;
      logic       commit;
      logic       mul;
      logic       div_init;
      logic       div_step;
      logic       mul2;
      logic       advance;
      logic       out_load;
      status_type out_code;
   } ctrl_cmd_type;

   typedef struct packed {
      logic start_ok;
      logic active;
      logic out_free;
   } dp_status_type;

endpackage

// File: src/srbag_div.sv
// ----------------------------------------------------------------------------
// Two-lane restoring divider
// Divides the column and row products by the destination sizes, one
// quotient bit per lane in each cycle in which step is high.
// ----------------------------------------------------------------------------
module srbag_div (
   input  logic                                                          clock,
   input  logic                                                          init,
   input  logic                                                          step,
   input  logic [srbag_pkg::NUM_LANES-1:0][srbag_pkg::PROD_BITS-1:0]     dividend,
   input  logic [srbag_pkg::NUM_LANES-1:0][srbag_pkg::SIZE_BITS-1:0]     divisor,
   output logic [srbag_pkg::NUM_LANES-1:0][srbag_pkg::COORD_BITS-1:0]    quotient
);
   import srbag_pkg::*;

   logic [NUM_LANES-1:0][SIZE_BITS-1:0]  rem_ff,  rem_in;
   logic [NUM_LANES-1:0][COORD_BITS-1:0] bits_ff, bits_in;
   logic [NUM_LANES-1:0][SIZE_BITS:0]    trial;
   logic [NUM_LANES-1:0][SIZE_BITS:0]    trial_diff;
   logic [NUM_LANES-1:0]                 qbit;

   // The quotient is known to fit COORD_BITS, so the upper half of the
   // dividend is already below the divisor and seeds the remainder.
   always_comb begin
      for (int l = 0; l < NUM_LANES; l++) begin
         trial[l]      = {rem_ff[l], bits_ff[l][COORD_BITS-1]};
         trial_diff[l] = trial[l] - (SIZE_BITS+1)'(divisor[l]);
         qbit[l]       = (trial[l] >= (SIZE_BITS+1)'(divisor[l]));
         rem_in[l]     = rem_ff[l];
         bits_in[l]    = bits_ff[l];
         if (init) begin
            rem_in[l]  = SIZE_BITS'(dividend[l][PROD_BITS-1:COORD_BITS]);
            bits_in[l] = dividend[l][COORD_BITS-1:0];
         end else if (step) begin
            rem_in[l]  = qbit[l] ? trial_diff[l][SIZE_BITS-1:0] : trial[l][SIZE_BITS-1:0];
            bits_in[l] = {bits_ff[l][COORD_BITS-2:0], qbit[l]};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
   end

   assign quotient = bits_ff;

endmodule

// File: src/srbag_dpath.sv
// ----------------------------------------------------------------------------
// Blit address datapath
// Configuration registers, rectangle setup, walk indices, multipliers,
// the shared divider and the result register.
// ----------------------------------------------------------------------------
`include "scaled_rect_blit_addr_gen_unit_defines.svh"

module srbag_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [srbag_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srbag_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [srbag_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [srbag_pkg::STATUS_BITS-1:0]     rsp_tuser,
   output logic [srbag_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  srbag_pkg::ctrl_cmd_type               dp_cmd,
   output srbag_pkg::dp_status_type              dp_sts
);
   import srbag_pkg::*;

   function automatic logic [ADDR_BITS-1:0] addr_sum(input logic [SUM_BITS-1:0] a,
                                                      input logic [SUM_BITS-1:0] b,
                                                      input logic [SUM_BITS-1:0] c);
      logic [SUM_BITS-1:0] s;
      s = a + b + c;
      return s[ADDR_BITS-1:0];
   endfunction

   // Configuration registers.
   logic [ADDR_BITS-1:0]  dst_base_ff, src_base_ff;
   logic [COORD_BITS-1:0] dst_width_ff, dst_height_ff, dst_stride_ff;
   logic [COORD_BITS-1:0] src_width_ff, src_height_ff;

   // Captured, ordered rectangle corners.
   logic [COORD_BITS-1:0] c_in [8];
   logic [COORD_BITS-1:0] sx_lo_in, sx_hi_in, sy_lo_in, sy_hi_in;
   logic [COORD_BITS-1:0] dx_lo_in, dx_hi_in, dy_lo_in, dy_hi_in;
   logic [COORD_BITS-1:0] sx_lo_ff, sx_hi_ff, sy_lo_ff, sy_hi_ff;
   logic [COORD_BITS-1:0] dx_lo_ff, dx_hi_ff, dy_lo_ff, dy_hi_ff;

   // Blit state.
   logic                  active_ff, active_in;
   logic [COORD_BITS-1:0] col_ff, col_in, row_ff, row_in;
   logic [SIZE_BITS-1:0]  clip_cols_ff, clip_rows_ff, x_size_ff, y_size_ff;
   logic [COORD_BITS-1:0] x_span_ff, y_span_ff;
   logic [ADDR_BITS-1:0]  src_origin_ff, dst_origin_ff;

   // Products and partial sums.
   logic [PROD_BITS-1:0]  prod_a_ff, prod_b_ff, prod_x_ff, prod_y_ff, prod_d_ff, prod_s_ff;
   logic [ADDR_BITS-1:0]  dst_sum_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ADDR_BITS-1:0]  rsp_src_ff, rsp_src_in, rsp_dst_ff, rsp_dst_in;

   logic [NUM_LANES-1:0][COORD_BITS-1:0] quot;
   logic                  start_ok;
   logic [SIZE_BITS-1:0]  dst_width_x, dst_height_x;
   logic [SIZE_BITS-1:0]  col_next, row_next;
   logic                  wrap_col, wrap_row;
   logic                  out_free;
   logic [ADDR_BITS-1:0]  src_addr;

   assign csr_ready = 1'b1;

   // Unpack and order the corner pairs.
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         c_in[i] = req_tdata[i*COORD_BITS +: COORD_BITS];
      end
      sx_lo_in = (c_in[0] > c_in[2]) ? c_in[2] : c_in[0];
      sx_hi_in = (c_in[0] > c_in[2]) ? c_in[0] : c_in[2];
      sy_lo_in = (c_in[1] > c_in[3]) ? c_in[3] : c_in[1];
      sy_hi_in = (c_in[1] > c_in[3]) ? c_in[1] : c_in[3];
      dx_lo_in = (c_in[4] > c_in[6]) ? c_in[6] : c_in[4];
      dx_hi_in = (c_in[4] > c_in[6]) ? c_in[4] : c_in[6];
      dy_lo_in = (c_in[5] > c_in[7]) ? c_in[7] : c_in[5];
      dy_hi_in = (c_in[5] > c_in[7]) ? c_in[5] : c_in[7];
   end

   assign start_ok = (dx_lo_ff < dst_width_ff) && (dy_lo_ff < dst_height_ff) &&
                     (sx_hi_ff < src_width_ff) && (sy_hi_ff < src_height_ff);
   assign dst_width_x  = SIZE_BITS'(dst_width_ff);
   assign dst_height_x = SIZE_BITS'(dst_height_ff);

   // Walk position after this pair.
   assign col_next = SIZE_BITS'(col_ff) + SIZE_BITS'(1);
   assign row_next = SIZE_BITS'(row_ff) + SIZE_BITS'(1);
   assign wrap_col = (col_next >= clip_cols_ff);
   assign wrap_row = wrap_col && (row_next >= clip_rows_ff);

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign src_addr = addr_sum(SUM_BITS'(src_origin_ff), SUM_BITS'(quot[0]),
                              SUM_BITS'(prod_s_ff));

   always_comb begin
      active_in = active_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      // Any start drops the running blit; a good one is armed again at commit.
      if (dp_cmd.check) begin
         active_in = 1'b0;
      end
      if (dp_cmd.commit) begin
         active_in = 1'b1;
         col_in    = '0;
         row_in    = '0;
      end
      if (dp_cmd.advance) begin
         if (wrap_col) begin
            col_in = '0;
            if (wrap_row) begin
               row_in    = '0;
               active_in = 1'b0;
            end else begin
               row_in = row_next[COORD_BITS-1:0];
            end
         end else begin
            col_in = col_next[COORD_BITS-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_src_in    = rsp_src_ff;
      rsp_dst_in    = rsp_dst_ff;
      if (dp_cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (dp_cmd.out_code == RSP_PAIR) begin
            rsp_status_in = wrap_row ? RSP_LAST : RSP_PAIR;
            rsp_src_in    = src_addr;
            rsp_dst_in    = dst_sum_ff;
         end else begin
            rsp_status_in = dp_cmd.out_code;
            rsp_src_in    = '0;
            rsp_dst_in    = '0;
         end
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         dst_base_ff   <= '0;
         dst_width_ff  <= DST_WIDTH_RESET;
         dst_height_ff <= DST_HEIGHT_RESET;
         dst_stride_ff <= DST_STRIDE_RESET;
         src_base_ff   <= '0;
         src_width_ff  <= SRC_WIDTH_RESET;
         src_height_ff <= SRC_HEIGHT_RESET;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_DST_BASE:   dst_base_ff   <= csr_data[ADDR_BITS-1:0];
               CSR_DST_WIDTH:  dst_width_ff  <= csr_data[COORD_BITS-1:0];
               CSR_DST_HEIGHT: dst_height_ff <= csr_data[COORD_BITS-1:0];
               CSR_DST_STRIDE: dst_stride_ff <= csr_data[COORD_BITS-1:0];
               CSR_SRC_BASE:   src_base_ff   <= csr_data[ADDR_BITS-1:0];
               CSR_SRC_WIDTH:  src_width_ff  <= csr_data[COORD_BITS-1:0];
               CSR_SRC_HEIGHT: src_height_ff <= csr_data[COORD_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      rsp_status_ff <= rsp_status_in;
      rsp_src_ff    <= rsp_src_in;
      rsp_dst_ff    <= rsp_dst_in;
      if (dp_cmd.capture) begin
         sx_lo_ff <= sx_lo_in;
         sx_hi_ff <= sx_hi_in;
         sy_lo_ff <= sy_lo_in;
         sy_hi_ff <= sy_hi_in;
         dx_lo_ff <= dx_lo_in;
         dx_hi_ff <= dx_hi_in;
         dy_lo_ff <= dy_lo_in;
         dy_hi_ff <= dy_hi_in;
      end
      if (dp_cmd.check && start_ok) begin
         // A far corner at or past the surface edge clips to the edge.
         clip_cols_ff <= (dx_hi_ff >= dst_width_ff) ? dst_width_x - SIZE_BITS'(dx_lo_ff)
                         : SIZE_BITS'(dx_hi_ff) - SIZE_BITS'(dx_lo_ff) + SIZE_BITS'(1);
         clip_rows_ff <= (dy_hi_ff >= dst_height_ff) ? dst_height_x - SIZE_BITS'(dy_lo_ff)
                         : SIZE_BITS'(dy_hi_ff) - SIZE_BITS'(dy_lo_ff) + SIZE_BITS'(1);
         x_size_ff    <= SIZE_BITS'(dx_hi_ff) - SIZE_BITS'(dx_lo_ff) + SIZE_BITS'(1);
         y_size_ff    <= SIZE_BITS'(dy_hi_ff) - SIZE_BITS'(dy_lo_ff) + SIZE_BITS'(1);
         x_span_ff    <= sx_hi_ff - sx_lo_ff;
         y_span_ff    <= sy_hi_ff - sy_lo_ff;
         prod_a_ff    <= PROD_BITS'(sy_lo_ff) * PROD_BITS'(src_width_ff);
         prod_b_ff    <= PROD_BITS'(dy_lo_ff) * PROD_BITS'(dst_stride_ff);
      end
      if (dp_cmd.commit) begin
         src_origin_ff <= addr_sum(SUM_BITS'(src_base_ff), SUM_BITS'(sx_lo_ff),
                                   SUM_BITS'(prod_a_ff));
         dst_origin_ff <= addr_sum(SUM_BITS'(dst_base_ff), SUM_BITS'(dx_lo_ff),
                                   SUM_BITS'(prod_b_ff));
      end
      if (dp_cmd.mul) begin
         prod_x_ff <= PROD_BITS'(col_ff) * PROD_BITS'(x_span_ff);
         prod_y_ff <= PROD_BITS'(row_ff) * PROD_BITS'(y_span_ff);
         prod_d_ff <= PROD_BITS'(row_ff) * PROD_BITS'(dst_stride_ff);
      end
      if (dp_cmd.mul2) begin
         // Source stride is read here, at each step.
         prod_s_ff  <= PROD_BITS'(quot[1]) * PROD_BITS'(src_width_ff);
         dst_sum_ff <= addr_sum(SUM_BITS'(dst_origin_ff), SUM_BITS'(col_ff),
                                SUM_BITS'(prod_d_ff));
      end
   end

   srbag_div u_div (
      .clock    (clock),
      .init     (dp_cmd.div_init),
      .step     (dp_cmd.div_step),
      .dividend ({prod_y_ff, prod_x_ff}),
      .divisor  ({y_size_ff, x_size_ff}),
      .quotient (quot)
   );

   assign dp_sts.start_ok = start_ok;
   assign dp_sts.active   = active_ff;
   assign dp_sts.out_free = out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_dst_ff, rsp_src_ff});

   `SRBAG_ASSERT_IMPLIES(a_col_in_clip, clock, reset, active_ff, SIZE_BITS'(col_ff) < clip_cols_ff)
   `SRBAG_ASSERT_IMPLIES(a_row_in_clip, clock, reset, active_ff, SIZE_BITS'(row_ff) < clip_rows_ff)
   `SRBAG_ASSERT_IMPLIES(a_non_pair_zero, clock, reset, rsp_valid_ff && rsp_status_ff != RSP_PAIR && rsp_status_ff != RSP_LAST, rsp_src_ff == '0 && rsp_dst_ff == '0)

endmodule

// File: src/srbag_ctrl.sv
// ----------------------------------------------------------------------------
// Blit address controller
// Sequences setup of a start command and the multiply, divide and add
// steps of a pixel step, one word at a time.
// ----------------------------------------------------------------------------
`include "scaled_rect_blit_addr_gen_unit_defines.svh"

module srbag_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tuser,
   output logic                      req_tready,
   input  srbag_pkg::dp_status_type  dp_sts,
   output srbag_pkg::ctrl_cmd_type   dp_cmd
);
   import srbag_pkg::*;

   localparam logic [DIV_CNT_BITS-1:0] CNT_LAST = DIV_CNT_BITS'(COORD_BITS - 1);

   ctrl_state_type          state_ff, state_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cnt_in          = cnt_ff;
      req_tready      = 1'b0;
      dp_cmd          = '0;
      dp_cmd.out_code = RSP_IDLE;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               dp_cmd.capture = 1'b1;
               if (command_type'(req_tuser) == CMD_START) begin
                  state_in = S_CHECK;
               end else if (dp_sts.active) begin
                  state_in = S_MUL;
               end else begin
                  state_in = S_IDLE_REPLY;
               end
            end
         end
         S_CHECK: begin
            dp_cmd.check = 1'b1;
            state_in     = dp_sts.start_ok ? S_COMMIT : S_REJECT;
         end
         S_COMMIT: begin
            dp_cmd.commit = 1'b1;
            state_in      = S_ACCEPT;
         end
         S_ACCEPT: begin
            if (dp_sts.out_free) begin
               dp_cmd.out_load = 1'b1;
               dp_cmd.out_code = RSP_ACCEPTED;
               state_in        = S_IDLE;
            end
         end
         S_REJECT: begin
            if (dp_sts.out_free) begin
               dp_cmd.out_load = 1'b1;
               dp_cmd.out_code = RSP_REJECTED;
               state_in        = S_IDLE;
            end
         end
         S_IDLE_REPLY: begin
            if (dp_sts.out_free) begin
               dp_cmd.out_load = 1'b1;
               dp_cmd.out_code = RSP_IDLE;
               state_in        = S_IDLE;
            end
         end
         S_MUL: begin
            dp_cmd.mul = 1'b1;
            state_in   = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            dp_cmd.div_init = 1'b1;
            cnt_in          = '0;
            state_in        = S_DIV;
         end
         S_DIV: begin
            dp_cmd.div_step = 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = S_MUL2;
            end else begin
               cnt_in = cnt_ff + DIV_CNT_BITS'(1);
            end
         end
         S_MUL2: begin
            dp_cmd.mul2 = 1'b1;
            state_in    = S_EMIT;
         end
         S_EMIT: begin
            if (dp_sts.out_free) begin
               dp_cmd.out_load = 1'b1;
               dp_cmd.out_code = RSP_PAIR;
               dp_cmd.advance  = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `SRBAG_ASSERT_NEXT(a_one_word_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready)
   `SRBAG_ASSERT_IMPLIES(a_div_count_bound, clock, reset, state_ff == S_DIV, cnt_ff <= CNT_LAST)
   `SRBAG_ASSERT_IMPLIES(a_div_after_init, clock, reset, dp_cmd.div_step, $past(dp_cmd.div_init) || $past(dp_cmd.div_step))

endmodule

// File: src/scaled_rect_blit_addr_gen_unit.sv
// ----------------------------------------------------------------------------
// Scaled rectangle blit address generator
// Produces source and destination word addresses for a nearest-neighbor
// scaled copy of a rectangle of 16-bit pixels.
// ----------------------------------------------------------------------------
// A start word (tuser 0) carries a source and a destination rectangle whose
// corners may come in either order. The block orders them, rejects the blit
// when the destination origin or the source far corner lies outside its
// surface, clips the destination to the surface, and answers with one word
// of status accepted or rejected. Each step word (tuser 1) then returns one
// source/destination address pair in row-major destination order, the last
// one flagged; a step with no blit armed answers idle. A start while a blit
// is running ends it, and an accepted start replaces it. Every request word
// yields exactly one response word. A start is captured, checked and, if
// good, committed before its status reaches the response register. A step's
// source offsets are index * span / size; both quotients come from a shared
// two-lane restoring divider retiring one quotient bit per cycle, which the
// step reaches after acceptance, a multiply and a divider load, and leaves
// through a multiply and an add. A new request word is taken only once the
// previous one has reached the response register, which may still be waiting
// on rsp_tready. The user must write configuration through the csr port only
// while no blit work is in flight, which the block does not enforce; the
// source width and destination stride are read live at every step.
module scaled_rect_blit_addr_gen_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request stream.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // tdata from bit 0 up: src_left, src_top, src_right, src_bottom,
   // dst_left, dst_top, dst_right, dst_bottom.
   input  logic [srbag_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // tuser: command.
   input  logic                                  req_tuser,
   // Response stream.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // tdata from bit 0 up: src_addr, dst_addr, zero-padded to whole bytes.
   output logic [srbag_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // tuser: status.
   output logic [srbag_pkg::STATUS_BITS-1:0]     rsp_tuser,
   // Configuration write channel.
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [srbag_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [srbag_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import srbag_pkg::*;

   ctrl_cmd_type  dp_cmd;
   dp_status_type dp_sts;

   // The controller owns the request handshake and sequencing.
   srbag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .dp_sts     (dp_sts),
      .dp_cmd     (dp_cmd)
   );

   // The datapath holds configuration, blit state and the response register.
   srbag_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .dp_cmd     (dp_cmd),
      .dp_sts     (dp_sts)
   );

endmodule
